// File: sv/plf_pkg.sv
// Shared types, constants and reset values for the priority LED status flasher.
package plf_pkg;

    // Field widths
    localparam int REQ_W      = 2;
    localparam int SRC_IDX_W  = 3;
    localparam int COLOR_W    = 2;
    localparam int FLASH_W    = 4;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Sources covered by the colour and flash tables
    localparam int TABLE_SOURCES = 8;
    localparam int COLOR_TBL_W   = TABLE_SOURCES * COLOR_W;
    localparam int FLASH_TBL_W   = TABLE_SOURCES * FLASH_W;

    localparam int NUM_SOURCES_DEF = 8;

    // Register reset values
    localparam logic [COLOR_TBL_W-1:0] COLOR_TBL_RST = 16'h4BF5;
    localparam logic [FLASH_TBL_W-1:0] FLASH_TBL_RST = 32'hF000500F;
    localparam logic [PERIOD_W-1:0]    PERIOD_RST    = 16'd350;

    // Flash count that never runs out
    localparam logic [FLASH_W-1:0] FLASH_FOREVER = 4'hF;
    localparam logic [COLOR_W-1:0] COLOR_OFF     = 2'd0;

    typedef enum logic [REQ_W-1:0] {
        REQ_SET     = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_LED_ON  = 2'd2,
        REQ_LED_OFF = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_TBL = 2'd0,
        CFG_FLASH_TBL = 2'd1,
        CFG_PERIOD    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_req                 req;
        logic [SRC_IDX_W-1:0] idx;
        logic                 on;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

    typedef struct packed {
        logic [COLOR_TBL_W-1:0] color_tbl;
        logic [FLASH_TBL_W-1:0] flash_tbl;
        logic [PERIOD_W-1:0]    period;
    } t_cfg;

endpackage

// File: sv/plf_cfg_regs.sv
// Configuration register file: colour table, flash table and flash period.
module plf_cfg_regs
    import plf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COLOR_TBL: n_cfg.color_tbl = i_cfg_data[COLOR_TBL_W-1:0];
                CFG_FLASH_TBL: n_cfg.flash_tbl = i_cfg_data[FLASH_TBL_W-1:0];
                CFG_PERIOD:    n_cfg.period    = i_cfg_data[PERIOD_W-1:0];
                default:       n_cfg = r_cfg;   // unmapped index: drop the write
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_tbl <= COLOR_TBL_RST;
            r_cfg.flash_tbl <= FLASH_TBL_RST;
            r_cfg.period    <= PERIOD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/plf_in_stage.sv
// Input register stage: captures one request per transfer and holds it until taken.
module plf_in_stage
    import plf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [SRC_IDX_W-1:0] i_source_index,
    input  logic                 i_source_on,
    output logic                 o_stall,
    output t_stage               o_stage,
    input  logic                 i_take
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.req <= t_req'(i_req_type);
            r_item.idx <= i_source_index;
            r_item.on  <= i_source_on;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

// File: sv/plf_engine.sv
// Status state, single-pass request update and result register.
module plf_engine
    import plf_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_stage             i_stage,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COLOR_W-1:0] o_led_color,
    output logic [COLOR_W-1:0] o_top_color,
    output logic               o_flash_active
);

    // Sources that have an entry in the tables
    localparam int LUT_SOURCES = (NUM_SOURCES < TABLE_SOURCES) ? NUM_SOURCES : TABLE_SOURCES;
    localparam int IDX_SPAN    = 1 << SRC_IDX_W;

    // Status state
    logic [NUM_SOURCES-1:0] r_en,      n_en;
    logic [COLOR_W-1:0]     r_chosen,  n_chosen;
    logic [COLOR_W-1:0]     r_driven,  n_driven;
    logic                   r_phase,   n_phase;
    logic                   r_out_en,  n_out_en;
    logic                   r_run,     n_run;
    logic [FLASH_W-1:0]     r_toggles, n_toggles;
    logic [PERIOD_W-1:0]    r_tick,    n_tick;

    // Result register
    logic                   r_ovalid,  n_ovalid;
    logic [COLOR_W-1:0]     r_led;
    logic [COLOR_W-1:0]     r_top;
    logic                   r_active;

    logic [NUM_SOURCES-1:0] set_en;
    logic [NUM_SOURCES-1:0] upd_en;
    logic [NUM_SOURCES-1:0] idx_hit;
    logic                   set_hit;
    logic [NUM_SOURCES-1:0] top_oh;
    logic                   top_any;
    logic [COLOR_W-1:0]     top_color;
    logic [FLASH_W-1:0]     top_flash;
    logic [PERIOD_W-1:0]    period_eff;
    logic [PERIOD_W-1:0]    tick_inc;
    logic [FLASH_W-1:0]     toggles_dec;
    t_item                  item;

    assign item   = i_stage.item;
    assign o_take = i_stage.valid && (!r_ovalid || !i_stall);

    // Apply the flag write of a set request
    always_comb begin
        set_en = r_en;
        for (int s = 0; s < NUM_SOURCES; s++) begin
            idx_hit[s] = (s < IDX_SPAN) && (item.idx == SRC_IDX_W'(s));
            if (idx_hit[s]) begin
                set_en[s] = item.on;
            end
        end
    end
    assign set_hit = |idx_hit;

    // Flags after this request
    assign upd_en = (o_take && (item.req == REQ_SET) && set_hit) ? set_en : r_en;

    // Highest-priority enabled source after this request, as a one-hot
    assign top_oh  = upd_en & (~upd_en + NUM_SOURCES'(1));
    assign top_any = |upd_en;

    always_comb begin
        top_color = COLOR_OFF;
        top_flash = '0;
        for (int s = 0; s < LUT_SOURCES; s++) begin
            if (top_oh[s]) begin
                top_color = top_color | i_cfg.color_tbl[COLOR_W*s +: COLOR_W];
                top_flash = top_flash | i_cfg.flash_tbl[FLASH_W*s +: FLASH_W];
            end
        end
    end

    assign period_eff  = (i_cfg.period == '0) ? PERIOD_W'(1) : i_cfg.period;
    assign tick_inc    = r_tick + PERIOD_W'(1);
    assign toggles_dec = (r_toggles != '0) ? (r_toggles - FLASH_W'(1)) : r_toggles;

    always_comb begin
        n_en      = r_en;
        n_chosen  = r_chosen;
        n_driven  = r_driven;
        n_phase   = r_phase;
        n_out_en  = r_out_en;
        n_run     = r_run;
        n_toggles = r_toggles;
        n_tick    = r_tick;
        if (o_take) begin
            unique case (item.req)
                REQ_SET: begin
                    if (set_hit) begin
                        n_en  = set_en;
                        n_run = 1'b0;
                        if (top_any) begin
                            n_chosen = top_color;
                            n_driven = r_out_en ? top_color : COLOR_OFF;
                            if (top_flash != '0) begin
                                n_run     = 1'b1;
                                n_toggles = top_flash;
                                n_tick    = '0;
                                n_phase   = 1'b1;
                            end
                        end else begin
                            n_chosen = COLOR_OFF;
                            n_driven = COLOR_OFF;
                        end
                    end
                end
                REQ_TICK: begin
                    if (r_run) begin
                        if (tick_inc >= period_eff) begin
                            n_tick  = '0;
                            n_phase = !r_phase;
                            if (r_phase) begin
                                n_driven = COLOR_OFF;
                            end else begin
                                n_driven = r_out_en ? r_chosen : COLOR_OFF;
                            end
                            if (r_toggles != FLASH_FOREVER) begin
                                n_toggles = toggles_dec;
                                if (toggles_dec == '0) begin
                                    n_run = 1'b0;
                                end
                            end
                        end else begin
                            n_tick = tick_inc;
                        end
                    end
                end
                REQ_LED_ON: begin
                    n_out_en = 1'b1;
                    n_driven = r_chosen;
                end
                REQ_LED_OFF: begin
                    n_out_en = 1'b0;
                    n_driven = COLOR_OFF;
                end
                default: begin
                    n_en = r_en;
                end
            endcase
        end
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (o_take) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= '0;
            r_chosen  <= COLOR_OFF;
            r_driven  <= COLOR_OFF;
            r_phase   <= 1'b0;
            r_out_en  <= 1'b1;
            r_run     <= 1'b0;
            r_toggles <= '0;
            r_tick    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_en      <= n_en;
            r_chosen  <= n_chosen;
            r_driven  <= n_driven;
            r_phase   <= n_phase;
            r_out_en  <= n_out_en;
            r_run     <= n_run;
            r_toggles <= n_toggles;
            r_tick    <= n_tick;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_led    <= n_driven;
            r_top    <= top_any ? top_color : COLOR_OFF;
            r_active <= n_run;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_led_color    = r_led;
    assign o_top_color    = r_top;
    assign o_flash_active = r_active;

    // A running flash always has toggles to spend
    a_run_has_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_toggles != '0))
        else $error("flash running with no toggles left");

    // Gated output drives nothing
    a_off_when_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_en |-> (r_driven == COLOR_OFF))
        else $error("LED driven while output disabled");

    // The LED shows either off or the chosen colour
    a_driven_is_chosen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_driven == COLOR_OFF) || (r_driven == r_chosen))
        else $error("LED colour differs from chosen colour");

    // No enabled source means no colour and no flash
    a_idle_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_en == '0) |-> ((r_chosen == COLOR_OFF) && !r_run))
        else $error("colour or flash left with no source enabled");

endmodule

// File: sv/priority_led_status_flasher.sv
// Top level of the priority LED status flasher.
//
// Keeps one enable flag per status source (source 0 wins) and drives a two-bit
// LED colour: 0 off, 1 red, 2 green, 3 orange. Each request transfer gives exactly
// one result transfer, reporting the state after that request. A set request
// writes one flag, picks the topmost enabled source, loads its colour from
// color_table and, when its flash_table count is nonzero, restarts a flash
// sequence (count 15 flashes forever). A tick request advances the flash timer;
// every flash_period_ticks ticks (zero acts as one) the LED toggles between off
// and the chosen colour. Enable and disable requests gate the LED. The block
// takes one request per clock while the result channel is not stalled; each
// request passes through the input register, then the state update through the
// priority pick and the 16-bit tick compare into the result register.
// While a result waits on a stalled output, one more request is held in the input
// register and then the input stalls until the result is taken. Write
// configuration only while no request is in flight.
module priority_led_status_flasher
    import plf_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [SRC_IDX_W-1:0]  i_source_index,
    input  logic                  i_source_on,
    // Result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COLOR_W-1:0]    o_led_color,
    output logic [COLOR_W-1:0]    o_top_color,
    output logic                  o_flash_active
);

    t_cfg   cfg;
    t_stage stage;
    logic   take;

    // Hold the three configuration registers
    plf_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Register each request transfer; stall only while a held request cannot advance
    plf_in_stage u_in_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_req_type     (i_req_type),
        .i_source_index (i_source_index),
        .i_source_on    (i_source_on),
        .o_stall        (o_stall),
        .o_stage        (stage),
        .i_take         (take)
    );

    // Update the status state and load the result register in one pass
    plf_engine #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_stage        (stage),
        .o_take         (take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_led_color    (o_led_color),
        .o_top_color    (o_top_color),
        .o_flash_active (o_flash_active)
    );

endmodule

// File: tb/tb_priority_led_status_flasher.sv
// Self-checking testbench for the priority LED status flasher: directed and random requests.
module tb_priority_led_status_flasher;
    import plf_pkg::*;

    localparam int NSRC = NUM_SOURCES_DEF;

    // What one result transfer carries.
    typedef struct packed {
        logic [COLOR_W-1:0] led;
        logic [COLOR_W-1:0] top;
        logic               active;
    } t_led_view;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  req_valid   = 1'b0;
    logic                  req_stall;
    logic [REQ_W-1:0]      req_type    = '0;
    logic [SRC_IDX_W-1:0]  req_source  = '0;
    logic                  req_on      = 1'b0;
    logic                  res_valid;
    logic                  res_stall   = 1'b0;
    logic [COLOR_W-1:0]    res_led;
    logic [COLOR_W-1:0]    res_top;
    logic                  res_active;

    // Requests waiting to be driven, and views of the LED still owed by the block.
    t_item     job_q[$];
    t_led_view view_q[$];
    t_item     cur_job;
    int        mismatches = 0;

    // Idle draws per transfer; a calm side runs back to back for a while.
    int        src_wait  = 0;
    int        snk_wait  = 0;
    bit        src_calm  = 1'b0;
    bit        snk_calm  = 1'b0;

    // Mirror of the block's registers and flasher state.
    logic [COLOR_TBL_W-1:0] mdl_color_tbl = COLOR_TBL_RST;
    logic [FLASH_TBL_W-1:0] mdl_flash_tbl = FLASH_TBL_RST;
    logic [PERIOD_W-1:0]    mdl_period    = PERIOD_RST;
    logic [NSRC-1:0]        mdl_enables   = '0;
    logic [COLOR_W-1:0]     mdl_chosen    = COLOR_OFF;
    logic [COLOR_W-1:0]     mdl_driven    = COLOR_OFF;
    logic                   mdl_phase     = 1'b0;
    logic                   mdl_led_en    = 1'b1;
    logic                   mdl_flashing  = 1'b0;
    logic [FLASH_W-1:0]     mdl_toggles   = '0;
    logic [PERIOD_W-1:0]    mdl_ticks     = '0;

    priority_led_status_flasher dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (req_valid),
        .o_stall        (req_stall),
        .i_req_type     (req_type),
        .i_source_index (req_source),
        .i_source_on    (req_on),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_led_color    (res_led),
        .o_top_color    (res_top),
        .o_flash_active (res_active)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Colour of a source; sources past the table read as off.
    function automatic logic [COLOR_W-1:0] color_for(int unsigned s);
        if (s >= TABLE_SOURCES) return COLOR_OFF;
        return mdl_color_tbl[COLOR_W*s +: COLOR_W];
    endfunction

    // Highest-priority enabled source, NSRC when none is enabled.
    function automatic int unsigned top_pick();
        for (int unsigned s = 0; s < NSRC; s++)
            if (mdl_enables[s]) return s;
        return NSRC;
    endfunction

    // Apply one request to the mirrored state and return the LED view after it.
    function automatic t_led_view advance_flasher(t_item it);
        int unsigned         s;
        logic [FLASH_W-1:0]  count;
        logic [PERIOD_W-1:0] span;
        t_led_view           v;
        case (it.req)
            REQ_SET: begin
                // Out-of-range sources leave everything as it is.
                if (it.idx < NSRC) begin
                    mdl_enables[it.idx] = it.on;
                    s = top_pick();
                    mdl_flashing = 1'b0;
                    if (s < NSRC) begin
                        count = (s < TABLE_SOURCES) ? mdl_flash_tbl[FLASH_W*s +: FLASH_W] : '0;
                        mdl_chosen = color_for(s);
                        mdl_driven = mdl_led_en ? mdl_chosen : COLOR_OFF;
                        // No flash count: stop flashing but keep the phase as it was.
                        if (count != '0) begin
                            mdl_flashing = 1'b1;
                            mdl_toggles  = count;
                            mdl_ticks    = '0;
                            mdl_phase    = 1'b1;
                        end
                    end else begin
                        mdl_chosen = COLOR_OFF;
                        mdl_driven = COLOR_OFF;
                    end
                end
            end
            REQ_TICK: begin
                if (mdl_flashing) begin
                    // A zero period counts as one tick.
                    span = (mdl_period == '0) ? PERIOD_W'(1) : mdl_period;
                    mdl_ticks = mdl_ticks + 1'b1;
                    if (mdl_ticks >= span) begin
                        mdl_ticks = '0;
                        // Phase toggles even while the LED is gated off.
                        if (mdl_phase) begin
                            mdl_driven = COLOR_OFF;
                            mdl_phase  = 1'b0;
                        end else begin
                            mdl_driven = mdl_led_en ? mdl_chosen : COLOR_OFF;
                            mdl_phase  = 1'b1;
                        end
                        if (mdl_toggles != FLASH_FOREVER) begin
                            if (mdl_toggles != '0) mdl_toggles = mdl_toggles - 1'b1;
                            if (mdl_toggles == '0) mdl_flashing = 1'b0;
                        end
                    end
                end
            end
            REQ_LED_ON: begin
                // Drive the chosen colour regardless of flash phase.
                mdl_led_en = 1'b1;
                mdl_driven = mdl_chosen;
            end
            default: begin
                mdl_led_en = 1'b0;
                mdl_driven = COLOR_OFF;
            end
        endcase
        s        = top_pick();
        v.led    = mdl_driven;
        v.top    = (s < NSRC) ? color_for(s) : COLOR_OFF;
        v.active = mdl_flashing;
        return v;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        // Cap the log; the count keeps going.
        if (mismatches <= 100)
            $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic queue_job(t_req req, int idx, bit on);
        t_item it;
        it.req = req;
        it.idx = SRC_IDX_W'(idx);
        it.on  = on;
        job_q.push_back(it);
    endtask

    // Mostly ticks and sets so flash sequences start, run and end; the rest gates the LED.
    function automatic t_item random_request();
        t_item it;
        int    pick;
        pick   = $urandom_range(0, 99);
        it.req = (pick < 30) ? REQ_SET : (pick < 80) ? REQ_TICK :
                 (pick < 90) ? REQ_LED_ON : REQ_LED_OFF;
        it.idx = SRC_IDX_W'($urandom_range(0, 7));
        it.on  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Write all three registers, one per clock, and mirror them.
    task automatic load_settings(logic [COLOR_TBL_W-1:0] colors, logic [FLASH_TBL_W-1:0] flashes,
                                 logic [PERIOD_W-1:0] period);
        t_cfg_idx r;
        for (int i = 0; i < 3; i++) begin
            r = t_cfg_idx'(i);
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= r;
            case (r)
                CFG_COLOR_TBL: cfg_data <= CFG_DATA_W'(colors);
                CFG_FLASH_TBL: cfg_data <= CFG_DATA_W'(flashes);
                default:       cfg_data <= CFG_DATA_W'(period);
            endcase
        end
        @(posedge clk);
        cfg_we        <= 1'b0;
        mdl_color_tbl  = colors;
        mdl_flash_tbl  = flashes;
        mdl_period     = period;
    endtask

    // Hold until every queued request has gone out and every view has come back.
    task automatic drain();
        do @(negedge clk);
        while (job_q.size() != 0 || req_valid || view_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Request driver: predict on each transfer, then present the next job after its gap.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            src_wait   = 0;
        end else begin
            if (req_valid && !req_stall)
                view_q.push_back(advance_flasher(cur_job));
            if (!req_valid || !req_stall) begin
                if (src_wait == 0 && job_q.size() != 0) begin
                    cur_job     = job_q.pop_front();
                    req_valid  <= 1'b1;
                    req_type   <= cur_job.req;
                    req_source <= cur_job.idx;
                    req_on     <= cur_job.on;
                    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
                    src_wait = src_calm ? 0 : $urandom_range(0, 13);
                end else begin
                    if (src_wait != 0) src_wait--;
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each transfer against the oldest view, then draw a stall.
    always @(posedge clk) begin
        t_led_view want;
        if (!rst_n) begin
            res_stall <= 1'b0;
            snk_wait   = 0;
        end else if (res_valid && !res_stall) begin
            if (view_q.size() == 0) begin
                report_mismatch("result with nothing outstanding", res_led, -1);
            end else begin
                want = view_q.pop_front();
                if (res_led !== want.led)       report_mismatch("led_color", res_led, want.led);
                if (res_top !== want.top)       report_mismatch("top_color", res_top, want.top);
                if (res_active !== want.active) report_mismatch("flash_active", res_active,
                                                                want.active);
            end
            if ($urandom_range(0, 39) == 0) snk_calm = !snk_calm;
            snk_wait   = snk_calm ? 0 : $urandom_range(0, 13);
            res_stall <= (snk_wait != 0);
        end else begin
            if (snk_wait != 0) snk_wait--;
            res_stall <= (snk_wait != 0);
        end
    end

    initial begin
        logic [PERIOD_W-1:0] period;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset tables: sources 0 and 7 flash forever, source 3 flashes five times.
        queue_job(REQ_LED_OFF, 0, 1'b0);
        queue_job(REQ_LED_ON,  7, 1'b1);
        queue_job(REQ_TICK,    0, 1'b0);   // no flash running: nothing moves
        queue_job(REQ_SET,     7, 1'b1);   // lowest priority, forever flash
        queue_job(REQ_SET,     1, 1'b1);   // no flash count: stop, keep phase
        queue_job(REQ_SET,     0, 1'b1);
        queue_job(REQ_LED_OFF, 5, 1'b0);
        queue_job(REQ_TICK,    7, 1'b1);
        queue_job(REQ_LED_ON,  2, 1'b0);
        queue_job(REQ_SET,     0, 1'b0);
        queue_job(REQ_SET,     1, 1'b0);
        queue_job(REQ_SET,     7, 1'b0);   // nothing enabled: LED off
        queue_job(REQ_SET,     3, 1'b1);
        drain();

        // Short flashes with a zero period, which acts as one tick.
        load_settings(16'hE4E4, 32'h0F20_1302, 16'd0);
        queue_job(REQ_SET,     0, 1'b1);   // off colour, two toggles
        queue_job(REQ_TICK,    0, 1'b0);
        queue_job(REQ_TICK,    0, 1'b0);
        queue_job(REQ_TICK,    0, 1'b0);   // finite flash already ended
        queue_job(REQ_SET,     0, 1'b0);   // source 3 takes over, one toggle
        queue_job(REQ_LED_OFF, 0, 1'b0);
        queue_job(REQ_TICK,    0, 1'b0);   // toggle while gated off
        queue_job(REQ_LED_ON,  0, 1'b0);
        queue_job(REQ_SET,     6, 1'b1);
        queue_job(REQ_SET,     3, 1'b0);   // source 6 flashes forever
        queue_job(REQ_TICK,    6, 1'b1);
        queue_job(REQ_TICK,    4, 1'b0);
        queue_job(REQ_SET,     6, 1'b0);
        drain();

        // Random phases; the first two take the register extremes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_settings('0, '0, 16'hFFFF);
                1: load_settings('1, '1, 16'd1);
                default: begin
                    period = (ph == 7) ? 16'd350 : PERIOD_W'($urandom_range(0, 4));
                    load_settings(COLOR_TBL_W'($urandom), FLASH_TBL_W'($urandom), period);
                end
            endcase
            for (int n = 0; n < 125; n++) begin
                job_q.push_back(random_request());
                // Halfway through, let everything in flight come back before going on.
                if (n == 62) drain();
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
sv/plf_pkg.sv
sv/plf_cfg_regs.sv
sv/plf_in_stage.sv
sv/plf_engine.sv
sv/priority_led_status_flasher.sv
tb/tb_priority_led_status_flasher.sv
